>>> design/slt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted list table
// no dependencies

package slt_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TotalW  = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    cmd_e cmd;
    logic hit;
  } ctrl_t;

endpackage

>>> design/sorted_list_table_top.sv
`timescale 1ns / 1ps
// sorted list table: sequencer, result register and a chain of compare/shift cells
// depends on slt_pkg and slt_cell
//
//  port group   dir  fields (lsb first)
//  s_axis       in   tdata: cmd[1:0], value[33:2]
//  m_axis       out  tdata: status[1:0], found[2], value_out[34:3],
//                          entry_total[39:35], is_empty[40]
//
// each word has a compare step, then an update step: the first latches every
// cell's compare against the operand, the second shifts the chain and loads the
// result register. the result register frees the next word while a result waits;
// the update cycle stalls only while the previous result is still unread.
// reset clears the valid bits and the count at once, no clearing pass.

module sorted_list_table_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [slt_pkg::InDataW-1:0]   s_axis_tdata,   // cmd, value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [slt_pkg::OutDataW-1:0]  m_axis_tdata    // status, found, value_out,
                                                        // entry_total, is_empty
);
  import slt_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                   state_q;
  cmd_e                     cmd_q;
  logic signed [ValueW-1:0] val_q;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q, out_data_d;

  ctrl_t                    ctrl;
  logic                     in_acc, exec_go, hit, full, drop;
  logic signed [ValueW-1:0] operand;

  logic signed [ValueW-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]         cell_valid, cell_ge, cell_hit;

  status_e                  status;
  logic                     found;
  logic signed [ValueW-1:0] vout;
  logic [31:0]              cnt_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign exec_go       = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  // compare runs on the incoming word, the update on the latched one
  assign operand = s_axis_tready ? s_axis_tdata[CmdW +: ValueW] : val_q;

  assign hit  = |cell_hit;
  assign full = cell_valid[DEPTH-1];
  // insert into a full table or delete of an absent value leaves the cells alone
  assign drop = ((cmd_q == CMD_INSERT) && full) || ((cmd_q == CMD_DELETE) && !hit);

  assign ctrl.cmp_en = in_acc;
  assign ctrl.upd_en = exec_go & ~drop;
  assign ctrl.cmd    = cmd_q;
  assign ctrl.hit    = hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] lv, rv;
    logic                     lvalid, lge, rvalid;
    if (i == 0) begin : g_first
      assign lv     = '0;
      assign lvalid = 1'b0;
      assign lge    = 1'b0;
    end else begin : g_mid
      assign lv     = cell_value[i-1];
      assign lvalid = cell_valid[i-1];
      assign lge    = cell_ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_inner
      assign rv     = cell_value[i+1];
      assign rvalid = cell_valid[i+1];
    end

    slt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .operand_i     (operand),
      .left_value_i  (lv),
      .left_valid_i  (lvalid),
      .left_ge_i     (lge),
      .right_value_i (rv),
      .right_valid_i (rvalid),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .ge_o          (cell_ge[i]),
      .hit_o         (cell_hit[i])
    );
  end

  always_comb begin
    cnt_d  = cnt_q;
    status = STAT_OK;
    found  = hit;
    vout   = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) status = STAT_FULL;
        else      cnt_d  = cnt_q + 1'b1;
      end
      CMD_DELETE: begin
        if (hit) begin
          cnt_d = cnt_q - 1'b1;
          vout  = val_q;
        end else begin
          status = STAT_NOT_FOUND;
        end
      end
      CMD_SEARCH: begin
        if (hit) vout   = val_q;
        else     status = STAT_NOT_FOUND;
      end
      CMD_CLEAR: begin
        cnt_d = '0;
        found = 1'b0;
      end
      default: cnt_d = cnt_q;
    endcase
  end

  assign cnt_ext    = 32'(cnt_d);
  assign out_data_d = {7'd0, (cnt_d == '0), cnt_ext[TotalW-1:0], vout, found, status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_q <= ST_IDLE;
            cnt_q   <= cnt_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_e'(s_axis_tdata[CmdW-1:0]);
      val_q <= s_axis_tdata[CmdW +: ValueW];
    end
    if (exec_go) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("entry count beyond table depth");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(cnt_q))
    else $error("valid cells disagree with entry count");

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_hit))
    else $error("more than one cell claims the match");

  a_exec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC) && !s_axis_tready)
    else $error("accepted word not executed");

endmodule

>>> design/slt_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted table: value, valid and registered compare flags
// depends on slt_pkg

module slt_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  slt_pkg::ctrl_t                     ctrl_i,
  input  logic signed [slt_pkg::ValueW-1:0]  operand_i,
  input  logic signed [slt_pkg::ValueW-1:0]  left_value_i,
  input  logic                               left_valid_i,
  input  logic                               left_ge_i,
  input  logic signed [slt_pkg::ValueW-1:0]  right_value_i,
  input  logic                               right_valid_i,
  output logic signed [slt_pkg::ValueW-1:0]  value_o,
  output logic                               valid_o,
  output logic                               ge_o,
  output logic                               hit_o
);
  import slt_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;
  logic                     valid_q, valid_d;
  logic                     ge_q, eq_q;
  logic                     first_ge;

  // this cell is the insertion point: first cell not below the operand
  assign first_ge = ge_q & ~left_ge_i;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.upd_en) begin
      case (ctrl_i.cmd)
        CMD_INSERT: begin
          if (first_ge) begin
            value_d = operand_i;
            valid_d = 1'b1;
          end else if (ge_q) begin
            value_d = left_value_i;
            valid_d = left_valid_i;
          end
        end
        CMD_DELETE: begin
          if (ge_q && ctrl_i.hit) begin
            value_d = right_value_i;
            valid_d = right_valid_i;
          end
        end
        CMD_CLEAR: valid_d = 1'b0;
        default: begin
          value_d = value_q;
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ge_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        ge_q <= ~(valid_q && (value_q < operand_i));
        eq_q <= valid_q && (value_q == operand_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign ge_o    = ge_q;
  assign hit_o   = first_ge & eq_q;

endmodule

>>> tb/sorted_list_table_top_test.sv
`timescale 1ns / 1ps
// testbench for sorted_list_table_top: directed and random command streams checked
// against a behavioral sorted table; depends on slt_pkg and the design sources

module sorted_list_table_top_test;
  import slt_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldOffAt   = 300;
  localparam int unsigned HoldOffLen  = 250;
  localparam int unsigned QuietFrom   = 550;
  localparam int unsigned QuietTo     = 700;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    cmd_e              cmd;
    logic [ValueW-1:0] value;
  } command_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [ValueW-1:0] value;
    logic [TotalW-1:0] total;
    logic              empty;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  command_t    command_q[$];
  reply_t      reply_q[$];
  logic signed [ValueW-1:0] table_vals [Depth];
  int          table_count = 0;
  logic        in_taken = 1'b0;
  int unsigned words_in = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  logic        quiet;

  sorted_list_table_top #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // no idling on either side while this window of words goes in
  assign quiet = (words_in >= QuietFrom) && (words_in < QuietTo);

  // sorted table update for one command, returns the reply it should produce
  function automatic reply_t apply_command(command_t c);
    reply_t r;
    int     pos;
    int     i;
    logic   hit;
    r = '0;
    r.status = STAT_OK;
    if (c.cmd == CMD_CLEAR) begin
      table_count = 0;
    end else begin
      pos = 0;
      while (pos < table_count && table_vals[pos] < $signed(c.value)) pos++;
      hit = (pos < table_count) && (table_vals[pos] == $signed(c.value));
      r.found = hit;
      case (c.cmd)
        CMD_INSERT: begin
          if (table_count >= Depth) begin
            r.status = STAT_FULL;
          end else begin
            for (i = table_count; i > pos; i--) table_vals[i] = table_vals[i-1];
            table_vals[pos] = c.value;
            table_count++;
          end
        end
        CMD_DELETE: begin
          if (!hit) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.value = table_vals[pos];
            for (i = pos; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
            table_count--;
          end
        end
        default: begin
          if (hit) r.value = table_vals[pos];
          else r.status = STAT_NOT_FOUND;
        end
      endcase
    end
    r.total = TotalW'(table_count);
    r.empty = (table_count == 0);
    return r;
  endfunction

  function automatic void note_failure(string what);
    if (errors < MaxReports) $display("[%0t] %s", $realtime, what);
    errors++;
  endfunction

  task automatic add_command(cmd_e cmd, logic [ValueW-1:0] value);
    command_t c;
    c.cmd = cmd;
    c.value = value;
    command_q.push_back(c);
  endtask

  // sender: a word stays offered until taken
  always @(negedge clk_i) begin
    command_t c;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (command_q.size() == 0 || (!quiet && $urandom_range(99) < 6)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        c = command_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'({c.value, c.cmd});
      end
    end
  end

  always @(posedge clk_i) begin
    command_t c;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.cmd = cmd_e'(s_axis_tdata[1:0]);
      c.value = s_axis_tdata[33:2];
      reply_q.push_back(apply_command(c));
      words_in <= words_in + 1;
    end
  end

  // receiver: random stalls plus one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (words_in >= HoldOffAt && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldOffLen;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tdata[1:0]);
      got.found  = m_axis_tdata[2];
      got.value  = m_axis_tdata[34:3];
      got.total  = m_axis_tdata[39:35];
      got.empty  = m_axis_tdata[40];
      if (reply_q.size() == 0) begin
        note_failure($sformatf("result word with none expected: %h", m_axis_tdata));
      end else begin
        want = reply_q.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.value !== want.value || got.total !== want.total ||
            got.empty !== want.empty) begin
          note_failure($sformatf(
            "mismatch: status %0d/%0d found %0b/%0b value %h/%h total %0d/%0d empty %0b/%0b",
            want.status, got.status, want.found, got.found, want.value, got.value,
            want.total, got.total, want.empty, got.empty));
        end
      end
    end
  end

  initial begin
    logic [ValueW-1:0] pool [6];
    int unsigned n;
    int unsigned k;
    int unsigned mode;
    int unsigned run_len;
    int unsigned roll;
    logic [ValueW-1:0] v;
    cmd_e cmd;

    // directed: empty-table misses, extremes, duplicates, full table, clear
    add_command(CMD_CLEAR, 32'h0000_0000);
    add_command(CMD_SEARCH, 32'h0000_0000);
    add_command(CMD_DELETE, 32'h0000_0005);
    add_command(CMD_INSERT, 32'h7fff_ffff);
    add_command(CMD_INSERT, 32'h8000_0000);
    add_command(CMD_INSERT, 32'h0000_0000);
    add_command(CMD_INSERT, 32'h0000_0000);
    add_command(CMD_INSERT, 32'hffff_ffff);
    for (k = 1; k <= 11; k++) add_command(CMD_INSERT, ValueW'(k * 7 - 40));
    add_command(CMD_INSERT, 32'h0000_0000);
    add_command(CMD_SEARCH, 32'h0000_0000);
    add_command(CMD_DELETE, 32'h0000_0000);
    add_command(CMD_SEARCH, 32'h8000_0000);
    add_command(CMD_DELETE, 32'h0000_3039);
    add_command(CMD_CLEAR, 32'hffff_ffff);

    // random runs: filling, draining or mixed, over a small pool so values repeat
    n = 0;
    while (n < RandomItems) begin
      mode = $urandom_range(2);
      run_len = $urandom_range(60, 10);
      for (k = 0; k < 6; k++) begin
        pool[k] = ($urandom_range(3) == 0) ? $urandom : ValueW'($urandom_range(40)) - 20;
      end
      if ($urandom_range(7) == 0) begin
        pool[4] = 32'h7fff_ffff;
        pool[5] = 32'h8000_0000;
      end
      for (k = 0; k < run_len; k++) begin
        roll = $urandom_range(99);
        case (mode)
          0: cmd = (roll < 70) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
                   (roll < 97) ? CMD_SEARCH : CMD_CLEAR;
          1: cmd = (roll < 20) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
                   (roll < 98) ? CMD_SEARCH : CMD_CLEAR;
          default: cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
                         (roll < 96) ? CMD_SEARCH : CMD_CLEAR;
        endcase
        v = ($urandom_range(9) < 8) ? pool[$urandom_range(5)] : $urandom;
        add_command(cmd, v);
        n++;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (command_q.size() == 0 && !s_axis_tvalid && reply_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (reply_q.size() != 0) note_failure("results still outstanding at end of run");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
